// ===== rtl/core/idq_pkg.sv =====
// ----------------------------------------------------------------------------
// idq_pkg
// Shared types and codes for the input-restricted deque: action and status
// codes, the data word type and the per-cycle operation sent to every cell.
// ----------------------------------------------------------------------------
package idq_pkg;

  localparam int DEPTH_DEFAULT = 8;
  localparam int WORD_W        = 32;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [1:0]               action_t;
  typedef logic [1:0]               status_t;

  localparam action_t ACT_PUSH      = 2'd0;
  localparam action_t ACT_POP_REAR  = 2'd1;
  localparam action_t ACT_POP_FRONT = 2'd2;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  localparam word_t EMPTY_WORD = -32'sd1;
  localparam word_t ZERO_WORD  = '0;

  // Operation broadcast to every cell of the row.
  typedef struct packed {
    logic push;       // shift words up, new word enters cell 0
    logic pop_rear;   // shift words and occupancy down
    logic pop_front;  // drop the front word and launch it toward cell 0
  } cell_op_t;

endpackage

// ===== rtl/core/input_restricted_deque_unit.sv =====
// ----------------------------------------------------------------------------
// input_restricted_deque_unit
// Input-restricted deque of DEPTH signed 32-bit words built as a row of cells.
// ----------------------------------------------------------------------------
// The deque is a row of DEPTH cells with the rear at cell 0. A push shifts
// every word up one cell and writes the new word into cell 0; a pop from the
// rear shifts every word down and returns the old cell 0. Occupancy is a
// thermometer of per-cell valid bits, so full means the top cell is occupied
// and empty means cell 0 is not. A pop from the front clears the highest
// occupied cell and hands its word down a registered return path, one cell
// per cycle, until it reaches cell 0. For a push, a pop from the rear, a
// refused word (full or empty) and the unused action code, the result word
// appears the cycle after the input word is taken. A pop from the front
// holding N words walks its word from cell N-1 down to cell 0 and then into
// the output register. New input words are stalled while that walk runs or
// while a result waits on a stalled output. Every input word gives exactly
// one result word.
// ----------------------------------------------------------------------------
module input_restricted_deque_unit #(
  parameter int DEPTH = idq_pkg::DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  idq_pkg::action_t action,
  input  idq_pkg::word_t   push_value,
  // output channel
  output logic             out_valid,
  input  logic             out_stall,
  output idq_pkg::word_t   popped_value,
  output idq_pkg::status_t status
);
  import idq_pkg::*;

  // Per-cell state, with one extra top position tied off as empty.
  word_t    cell_data  [DEPTH+1];
  logic     cell_valid [DEPTH+1];
  word_t    cell_ret   [DEPTH+1];
  logic     cell_retv  [DEPTH+1];

  cell_op_t op;
  logic     accept;
  logic     full;
  logic     empty;
  logic     walking;
  word_t    imm_value;
  status_t  imm_status;

  // Tie off the position above the top cell: never occupied, nothing returning.
  assign cell_data[DEPTH]  = ZERO_WORD;
  assign cell_valid[DEPTH] = 1'b0;
  assign cell_ret[DEPTH]   = ZERO_WORD;
  assign cell_retv[DEPTH]  = 1'b0;

  assign full   = cell_valid[DEPTH-1];
  assign empty  = ~cell_valid[0];

  // Hold off new words during a front-pop walk or while the result is stuck.
  assign in_stall = walking | (out_valid & out_stall);
  assign accept   = in_valid & ~in_stall;

  // Decode the accepted word into one operation for the whole row.
  always_comb begin
    op           = '0;
    imm_value    = ZERO_WORD;
    imm_status   = ST_DONE;
    unique case (action)
      ACT_PUSH: begin
        if (full) begin
          imm_status = ST_FULL;
        end else begin
          op.push = accept;
        end
      end
      ACT_POP_REAR: begin
        if (empty) begin
          imm_value  = EMPTY_WORD;
          imm_status = ST_EMPTY;
        end else begin
          op.pop_rear = accept;
          imm_value   = cell_data[0];
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          imm_value  = EMPTY_WORD;
          imm_status = ST_EMPTY;
        end else begin
          op.pop_front = accept;
        end
      end
      default: begin
        // unused code: no operation, done with zero
        imm_value  = ZERO_WORD;
        imm_status = ST_DONE;
      end
    endcase
  end

  // Row of cells: cell 0 is the rear and takes the pushed word.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t data_lo;
    logic  valid_lo;

    if (i == 0) begin : g_rear
      assign data_lo  = push_value;
      assign valid_lo = 1'b1;
    end else begin : g_inner
      assign data_lo  = cell_data[i-1];
      assign valid_lo = cell_valid[i-1];
    end

    idq_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .op           (op),
      .data_lo      (data_lo),
      .valid_lo     (valid_lo),
      .data_hi      (cell_data[i+1]),
      .valid_hi     (cell_valid[i+1]),
      .ret_hi       (cell_ret[i+1]),
      .ret_valid_hi (cell_retv[i+1]),
      .data         (cell_data[i]),
      .valid        (cell_valid[i]),
      .ret          (cell_ret[i]),
      .ret_valid    (cell_retv[i])
    );
  end

  // Front-pop walk: set on launch, drop once the word reaches cell 0.
  always_ff @(posedge clk) begin
    if (rst) begin
      walking <= 1'b0;
    end else if (op.pop_front) begin
      walking <= 1'b1;
    end else if (cell_retv[0]) begin
      walking <= 1'b0;
    end
  end

  // Output register: immediate results, then returned front words, else drain.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && !op.pop_front) begin
      out_valid <= 1'b1;
    end else if (cell_retv[0]) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !op.pop_front) begin
      popped_value <= imm_value;
      status       <= imm_status;
    end else if (cell_retv[0]) begin
      popped_value <= cell_ret[0];
      status       <= ST_DONE;
    end
  end

endmodule

// ===== rtl/core/idq_cell.sv =====
// ----------------------------------------------------------------------------
// idq_cell
// One position of the deque. Holds one word and its occupancy bit, and a
// return stage that walks the popped front word down toward cell 0.
// ----------------------------------------------------------------------------
module idq_cell (
  input  logic              clk,
  input  logic              rst,
  input  idq_pkg::cell_op_t op,
  input  idq_pkg::word_t    data_lo,
  input  logic              valid_lo,
  input  idq_pkg::word_t    data_hi,
  input  logic              valid_hi,
  input  idq_pkg::word_t    ret_hi,
  input  logic              ret_valid_hi,
  output idq_pkg::word_t    data,
  output logic              valid,
  output idq_pkg::word_t    ret,
  output logic              ret_valid
);
  import idq_pkg::*;

  logic is_front;

  // The front word sits in the highest occupied cell.
  assign is_front = valid & ~valid_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      ret_valid <= 1'b0;
    end else begin
      if (op.push) begin
        valid <= valid_lo;
      end else if (op.pop_rear || op.pop_front) begin
        valid <= valid_hi;
      end
      ret_valid <= (op.pop_front & is_front) | ret_valid_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (op.push) begin
      data <= data_lo;
    end else if (op.pop_rear) begin
      data <= data_hi;
    end
    if (op.pop_front && is_front) begin
      ret <= data;
    end else begin
      ret <= ret_hi;
    end
  end

endmodule

// ===== rtl/core/idq_checker.sv =====
// ----------------------------------------------------------------------------
// idq_checker
// Port-level checks on the deque's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module idq_checker (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input idq_pkg::word_t   popped_value,
  input idq_pkg::status_t status
);
  import idq_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(popped_value) && $stable(status))
    else $error("result word changed while stalled");

  // An empty refusal always returns all ones.
  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> popped_value == EMPTY_WORD)
    else $error("empty refusal without -1");

  // A full refusal returns zero.
  a_full_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> popped_value == ZERO_WORD)
    else $error("full refusal with nonzero value");

  // The first word after reset cannot find the deque full.
  a_reset_not_full: assert property (@(posedge clk)
    $fell(rst) |-> !(out_valid && status == ST_FULL))
    else $error("full refusal right after reset");

endmodule

bind input_restricted_deque_unit idq_checker u_idq_checker (.*);
